>>> rtl/acs_pkg.sv
// Package for the AT command setup sequencer.
// Holds the op, phase and status codes, register map, reply words and shared structs.
// No dependencies.
package acs_pkg;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned CMD_W      = 4;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_RX    = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ENABLE  = 3'd1,
    PH_STARTUP = 3'd2,
    PH_REPLY   = 3'd3,
    PH_EXIT    = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_BUSY      = 3'd1,
    ST_READY     = 3'd2,
    ST_ERR_REPLY = 3'd3,
    ST_TIMEOUT   = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE_SETTLE = 3'd0,
    REG_STARTUP_WAIT  = 3'd1,
    REG_REPLY_TIMEOUT = 3'd2,
    REG_EXIT_SETTLE   = 3'd3,
    REG_LAST_COMMAND  = 3'd4
  } reg_idx_e;

  localparam logic [DELAY_W-1:0] ENABLE_SETTLE_RST = 16'd200;
  localparam logic [DELAY_W-1:0] STARTUP_WAIT_RST  = 16'd300;
  localparam logic [DELAY_W-1:0] REPLY_TIMEOUT_RST = 16'd1000;
  localparam logic [DELAY_W-1:0] EXIT_SETTLE_RST   = 16'd200;
  localparam logic [CMD_W-1:0]   LAST_COMMAND_RST  = 4'd3;

  // Reply words matched byte by byte
  localparam logic [1:0] OK_LEN  = 2'd2;
  localparam logic [2:0] ERR_LEN = 3'd5;
  localparam logic [7:0] OK_WORD  [2] = '{8'h4F, 8'h4B};                      // "OK"
  localparam logic [7:0] ERR_WORD [5] = '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52}; // "ERROR"

  typedef struct packed {
    logic [DELAY_W-1:0] enable_settle;
    logic [DELAY_W-1:0] startup_wait;
    logic [DELAY_W-1:0] reply_timeout;
    logic [DELAY_W-1:0] exit_settle;
    logic [CMD_W-1:0]   last_command;
  } cfg_t;

  typedef struct packed {
    status_e          status;
    logic             start_accepted;
    logic             enable_level;
    logic             command_baud;
    logic             send_command;
    logic [CMD_W-1:0] command_number;
  } result_t;

endpackage

>>> rtl/acs_cfg_regs.sv
// Configuration register file of the AT command setup sequencer, APB-style access.
// Depends on acs_pkg (register map, reset values, cfg_t).
module acs_cfg_regs
  import acs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t                 cfg_q, cfg_d;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[CFG_ADDR_W-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_ENABLE_SETTLE: cfg_d.enable_settle = pwdata[DELAY_W-1:0];
        REG_STARTUP_WAIT:  cfg_d.startup_wait  = pwdata[DELAY_W-1:0];
        REG_REPLY_TIMEOUT: cfg_d.reply_timeout = pwdata[DELAY_W-1:0];
        REG_EXIT_SETTLE:   cfg_d.exit_settle   = pwdata[DELAY_W-1:0];
        REG_LAST_COMMAND:  cfg_d.last_command  = pwdata[CMD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLE_SETTLE: prdata = {16'd0, cfg_q.enable_settle};
      REG_STARTUP_WAIT:  prdata = {16'd0, cfg_q.startup_wait};
      REG_REPLY_TIMEOUT: prdata = {16'd0, cfg_q.reply_timeout};
      REG_EXIT_SETTLE:   prdata = {16'd0, cfg_q.exit_settle};
      REG_LAST_COMMAND:  prdata = {28'd0, cfg_q.last_command};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_settle <= ENABLE_SETTLE_RST;
      cfg_q.startup_wait  <= STARTUP_WAIT_RST;
      cfg_q.reply_timeout <= REPLY_TIMEOUT_RST;
      cfg_q.exit_settle   <= EXIT_SETTLE_RST;
      cfg_q.last_command  <= LAST_COMMAND_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/acs_core.sv
// Sequencer state and single-pass step logic: deadlines, reply matching, command stepping.
// Depends on acs_pkg (codes, reply words, cfg_t, result_t).
module acs_core
  import acs_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [1:0]  op_i,
  input  logic [31:0] now_ms_i,
  input  logic [7:0]  rx_byte_i,
  input  cfg_t        cfg_i,
  output result_t     result_o
);

  phase_e               phase_q, phase_d;
  status_e              report_q, report_d;
  logic [TIME_BITS-1:0] deadline_q, deadline_d;
  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic [1:0]           ok_prog_q, ok_prog_d;
  logic [2:0]           err_prog_q, err_prog_d;
  logic                 ok_seen_q, ok_seen_d;
  logic                 err_seen_q, err_seen_d;
  logic                 enable_q, enable_d;
  logic                 baud_q, baud_d;
  logic                 accepted, send;
  logic [TIME_BITS-1:0] now_w;
  logic                 hit;

  assign now_w = TIME_BITS'(now_ms_i);

  // Wrap-safe compare: reached when (now - deadline) has its top bit clear
  logic [TIME_BITS-1:0] diff;
  assign diff = now_w - deadline_q;
  assign hit  = ~diff[TIME_BITS-1];

  // Next state
  always_comb begin
    phase_d    = phase_q;
    report_d   = report_q;
    deadline_d = deadline_q;
    cmd_d      = cmd_q;
    ok_prog_d  = ok_prog_q;
    err_prog_d = err_prog_q;
    ok_seen_d  = ok_seen_q;
    err_seen_d = err_seen_q;
    enable_d   = enable_q;
    baud_d     = baud_q;
    accepted   = 1'b0;
    send       = 1'b0;
    if (step_i) begin
      unique case (op_e'(op_i))
        OP_START: begin
          if (report_q != ST_BUSY) begin
            accepted   = 1'b1;
            enable_d   = 1'b1;
            cmd_d      = '0;
            deadline_d = now_w + TIME_BITS'(cfg_i.enable_settle);
            phase_d    = PH_ENABLE;
            report_d   = ST_BUSY;
          end
        end
        OP_TICK: begin
          if (report_q == ST_BUSY) begin
            unique case (phase_q)
              PH_ENABLE: begin
                if (hit) begin
                  baud_d     = 1'b1;
                  ok_prog_d  = '0;
                  err_prog_d = '0;
                  ok_seen_d  = 1'b0;
                  err_seen_d = 1'b0;
                  deadline_d = now_w + TIME_BITS'(cfg_i.startup_wait);
                  phase_d    = PH_STARTUP;
                end
              end
              PH_STARTUP: begin
                if (hit) begin
                  ok_prog_d  = '0;
                  err_prog_d = '0;
                  ok_seen_d  = 1'b0;
                  err_seen_d = 1'b0;
                  deadline_d = now_w + TIME_BITS'(cfg_i.reply_timeout);
                  phase_d    = PH_REPLY;
                  send       = 1'b1;
                end
              end
              PH_REPLY: begin
                if (err_seen_q) begin
                  enable_d = 1'b0;
                  baud_d   = 1'b0;
                  phase_d  = PH_IDLE;
                  report_d = ST_ERR_REPLY;
                end else if (ok_seen_q) begin
                  if (cmd_q < cfg_i.last_command) begin
                    cmd_d      = cmd_q + 1'b1;
                    ok_prog_d  = '0;
                    err_prog_d = '0;
                    ok_seen_d  = 1'b0;
                    err_seen_d = 1'b0;
                    deadline_d = now_w + TIME_BITS'(cfg_i.reply_timeout);
                    phase_d    = PH_REPLY;
                    send       = 1'b1;
                  end else begin
                    enable_d   = 1'b0;
                    deadline_d = now_w + TIME_BITS'(cfg_i.exit_settle);
                    phase_d    = PH_EXIT;
                  end
                end else if (hit) begin
                  enable_d = 1'b0;
                  baud_d   = 1'b0;
                  phase_d  = PH_IDLE;
                  report_d = ST_TIMEOUT;
                end
              end
              PH_EXIT: begin
                if (hit) begin
                  baud_d   = 1'b0;
                  phase_d  = PH_IDLE;
                  report_d = ST_READY;
                end
              end
              default: ;
            endcase
          end
        end
        OP_RX: begin
          if (report_q == ST_BUSY && phase_q == PH_REPLY && !err_seen_q) begin
            // ERROR match first; a completed ERROR leaves the OK match untouched
            if (err_prog_q < ERR_LEN && rx_byte_i == ERR_WORD[err_prog_q]) begin
              err_prog_d = err_prog_q + 1'b1;
            end else begin
              err_prog_d = (rx_byte_i == ERR_WORD[0]) ? 3'd1 : 3'd0;
            end
            if (err_prog_d == ERR_LEN) begin
              err_seen_d = 1'b1;
            end else if (ok_prog_q < OK_LEN && rx_byte_i == OK_WORD[ok_prog_q[0]]) begin
              if (ok_prog_q + 1'b1 == OK_LEN) begin
                ok_seen_d = 1'b1;
                ok_prog_d = '0;
              end else begin
                ok_prog_d = ok_prog_q + 1'b1;
              end
            end else begin
              ok_prog_d = (rx_byte_i == OK_WORD[0]) ? 2'd1 : 2'd0;
            end
          end
        end
        OP_NOP: ;
        default: ;
      endcase
    end
  end

  // Result reflects the state after the step
  always_comb begin
    result_o.status         = report_d;
    result_o.start_accepted = accepted;
    result_o.enable_level   = enable_d;
    result_o.command_baud   = baud_d;
    result_o.send_command   = send;
    result_o.command_number = cmd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      report_q   <= ST_IDLE;
      deadline_q <= '0;
      cmd_q      <= '0;
      ok_prog_q  <= '0;
      err_prog_q <= '0;
      ok_seen_q  <= 1'b0;
      err_seen_q <= 1'b0;
      enable_q   <= 1'b0;
      baud_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      report_q   <= report_d;
      deadline_q <= deadline_d;
      cmd_q      <= cmd_d;
      ok_prog_q  <= ok_prog_d;
      err_prog_q <= err_prog_d;
      ok_seen_q  <= ok_seen_d;
      err_seen_q <= err_seen_d;
      enable_q   <= enable_d;
      baud_q     <= baud_d;
    end
  end

`ifndef SYNTHESIS
  a_enable_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !enable_q |-> (phase_q == PH_IDLE || phase_q == PH_EXIT))
    else $error("enable low in an active phase");
  a_baud_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    baud_q |-> report_q == ST_BUSY)
    else $error("command baud held outside a busy sequence");
  // the flag outlives the failed sequence until the next sequence leaves its enable phase and clears it
  a_err_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_seen_q |-> err_prog_q == ERR_LEN)
    else $error("error flag without a full ERROR match");
  a_ok_prog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ok_prog_q < OK_LEN)
    else $error("OK match progress out of range");
`endif

endmodule

>>> rtl/at_command_config_sequencer.sv
// AT command setup sequencer: usage
// Input channel (in_valid_i/in_ready_o) carries op_i, now_ms_i and rx_byte_i.
//   op 0 start, op 1 update tick, op 2 received reply byte, op 3 no-op.
// Output channel (out_valid_o/out_ready_i) returns exactly one result per
//   transaction: status, start_accepted, enable level, command baud,
//   send_command and command_number, in order.
// Path: an accepted input waits in the input register, then the step logic
//   writes the result register, which drives out_valid_o.
// Throughput: one transaction per cycle while the output is not stalled; the
//   step logic is combinational between the sequencer state registers, so
//   consecutive items chain.
// Stall: when out_ready_i is low the result is held; the input register
//   still takes one more transaction, then in_ready_o drops until the
//   result drains.
// Reset (rst_ni low, async): sequencer idle, enable and command baud low,
//   registers back to 200/300/1000/200 ms and last command 3.
// Configuration: APB-style, registers at byte offsets 0,4,8,12,16; write only
//   while no transaction is in flight.
// Depends on acs_pkg, acs_cfg_regs, acs_core.
module at_command_config_sequencer
  import acs_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            op_i,
  input  logic [31:0]           now_ms_i,
  input  logic [7:0]            rx_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            status_o,
  output logic                  start_accepted_o,
  output logic                  enable_level_o,
  output logic                  command_baud_o,
  output logic                  send_command_o,
  output logic [CMD_W-1:0]      command_number_o
);

  cfg_t        cfg;
  result_t     result;
  result_t     out_q;
  logic        out_valid_q, out_valid_d;
  logic        in_valid_q, in_valid_d;
  logic [1:0]  op_q;
  logic [31:0] now_q;
  logic [7:0]  byte_q;
  logic        advance;
  logic        take;

  // Registered item moves to the result stage when that stage is free or draining
  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;
  assign take       = in_valid_i & in_ready_o;

  assign in_valid_d  = take | (in_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & ~out_ready_i);

  acs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  acs_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .op_i      (op_q),
    .now_ms_i  (now_q),
    .rx_byte_i (byte_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q   <= op_i;
      now_q  <= now_ms_i;
      byte_q <= rx_byte_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign start_accepted_o = out_q.start_accepted;
  assign enable_level_o   = out_q.enable_level;
  assign command_baud_o   = out_q.command_baud;
  assign send_command_o   = out_q.send_command;
  assign command_number_o = out_q.command_number;

`ifndef SYNTHESIS
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("buffered transaction dropped without a step");
  a_send_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && send_command_o) |-> (status_o == ST_BUSY && command_baud_o))
    else $error("command issued outside a busy sequence");
  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && start_accepted_o) |-> (enable_level_o && status_o == ST_BUSY))
    else $error("accepted start without enable and busy");
`endif

endmodule

>>> tb/acs_monitor.sv
// Checker for the AT command setup sequencer: tracks APB writes, predicts one
// result per input transaction and compares it with the output channel.
// Depends on acs_pkg.
module acs_monitor
  import acs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [CFG_ADDR_W-1:0] paddr_i,
  input  logic [31:0]           pwdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [1:0]            op_i,
  input  logic [31:0]           now_ms_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [2:0]            status_i,
  input  logic                  start_accepted_i,
  input  logic                  enable_level_i,
  input  logic                  command_baud_i,
  input  logic                  send_command_i,
  input  logic [CMD_W-1:0]      command_number_i,
  output int                    errors_o,
  output int                    pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_K = 8'h4B;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_R = 8'h52;

  cfg_t             cfg;
  phase_e           phase;
  status_e          report;
  logic [31:0]      deadline;
  logic [CMD_W-1:0] cmd_idx;
  logic [1:0]       ok_prog;
  logic [2:0]       err_prog;
  logic             ok_seen;
  logic             err_seen;
  logic             enable_q;
  logic             baud_q;

  result_t seq_outputs_q[$];
  result_t predicted;
  result_t expected;

  function automatic logic [7:0] error_char(input logic [2:0] pos);
    case (pos)
      3'd0:    return CH_E;
      3'd3:    return CH_O;
      default: return CH_R;
    endcase
  endfunction

  // wrap-safe: reached once now - deadline has its top bit clear
  function automatic logic due(input logic [31:0] now);
    logic [31:0] diff;
    diff = now - deadline;
    return !diff[31];
  endfunction

  task automatic clear_reply();
    ok_prog  = '0;
    err_prog = '0;
    ok_seen  = 1'b0;
    err_seen = 1'b0;
  endtask

  task automatic arm_reply(input logic [31:0] now);
    clear_reply();
    deadline = now + {16'd0, cfg.reply_timeout};
    phase    = PH_REPLY;
  endtask

  task automatic abort_sequence(input status_e code);
    enable_q = 1'b0;
    baud_q   = 1'b0;
    phase    = PH_IDLE;
    report   = code;
  endtask

  task automatic match_reply_byte(input logic [7:0] b);
    logic err_done;
    err_done = 1'b0;
    if (err_prog < ERR_LEN && b == error_char(err_prog)) begin
      err_prog = err_prog + 3'd1;
      if (err_prog == ERR_LEN) begin
        err_seen = 1'b1;
        err_done = 1'b1;
      end
    end else begin
      err_prog = (b == CH_E) ? 3'd1 : 3'd0;
    end
    if (!err_done) begin
      if (ok_prog < OK_LEN && b == ((ok_prog == 2'd0) ? CH_O : CH_K)) begin
        // a complete OK rearms the OK match
        if (ok_prog == 2'd1) begin
          ok_seen = 1'b1;
          ok_prog = 2'd0;
        end else begin
          ok_prog = 2'd1;
        end
      end else begin
        ok_prog = (b == CH_O) ? 2'd1 : 2'd0;
      end
    end
  endtask

  task automatic step_sequencer(input op_e op, input logic [31:0] now,
                                input logic [7:0] b, output result_t r);
    logic taken;
    logic send;
    taken = 1'b0;
    send  = 1'b0;
    case (op)
      OP_START: begin
        if (report != ST_BUSY) begin
          taken    = 1'b1;
          enable_q = 1'b1;
          cmd_idx  = '0;
          deadline = now + {16'd0, cfg.enable_settle};
          phase    = PH_ENABLE;
          report   = ST_BUSY;
        end
      end
      OP_TICK: begin
        if (report == ST_BUSY) begin
          case (phase)
            PH_ENABLE: begin
              if (due(now)) begin
                baud_q = 1'b1;
                clear_reply();
                deadline = now + {16'd0, cfg.startup_wait};
                phase    = PH_STARTUP;
              end
            end
            PH_STARTUP: begin
              if (due(now)) begin
                arm_reply(now);
                send = 1'b1;
              end
            end
            PH_REPLY: begin
              if (err_seen) begin
                abort_sequence(ST_ERR_REPLY);
              end else if (ok_seen) begin
                if (cmd_idx < cfg.last_command) begin
                  cmd_idx = cmd_idx + 1'b1;
                  arm_reply(now);
                  send = 1'b1;
                end else begin
                  enable_q = 1'b0;
                  deadline = now + {16'd0, cfg.exit_settle};
                  phase    = PH_EXIT;
                end
              end else if (due(now)) begin
                abort_sequence(ST_TIMEOUT);
              end
            end
            PH_EXIT: begin
              if (due(now)) begin
                baud_q = 1'b0;
                phase  = PH_IDLE;
                report = ST_READY;
              end
            end
            default: ;
          endcase
        end
      end
      OP_RX: begin
        if (report == ST_BUSY && phase == PH_REPLY && !err_seen) begin
          match_reply_byte(b);
        end
      end
      default: ;
    endcase
    r.status         = report;
    r.start_accepted = taken;
    r.enable_level   = enable_q;
    r.command_baud   = baud_q;
    r.send_command   = send;
    r.command_number = cmd_idx;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.enable_settle = ENABLE_SETTLE_RST;
      cfg.startup_wait  = STARTUP_WAIT_RST;
      cfg.reply_timeout = REPLY_TIMEOUT_RST;
      cfg.exit_settle   = EXIT_SETTLE_RST;
      cfg.last_command  = LAST_COMMAND_RST;
      phase    = PH_IDLE;
      report   = ST_IDLE;
      deadline = '0;
      cmd_idx  = '0;
      clear_reply();
      enable_q = 1'b0;
      baud_q   = 1'b0;
      seq_outputs_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      // drain before push: a result can never belong to a same-cycle input
      if (out_valid_i && out_ready_i) begin
        if (seq_outputs_q.size() == 0) begin
          $error("result with no transaction waiting: status %0d", status_i);
          errors_o++;
        end else begin
          expected = seq_outputs_q.pop_front();
          check_field("status", int'(expected.status), int'(status_i));
          check_field("start_accepted", int'(expected.start_accepted),
                      int'(start_accepted_i));
          check_field("enable_level", int'(expected.enable_level), int'(enable_level_i));
          check_field("command_baud", int'(expected.command_baud), int'(command_baud_i));
          check_field("send_command", int'(expected.send_command), int'(send_command_i));
          check_field("command_number", int'(expected.command_number),
                      int'(command_number_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        step_sequencer(op_e'(op_i), now_ms_i, rx_byte_i, predicted);
        seq_outputs_q.push_back(predicted);
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[CFG_ADDR_W-1:2]))
          REG_ENABLE_SETTLE: cfg.enable_settle = pwdata_i[DELAY_W-1:0];
          REG_STARTUP_WAIT:  cfg.startup_wait  = pwdata_i[DELAY_W-1:0];
          REG_REPLY_TIMEOUT: cfg.reply_timeout = pwdata_i[DELAY_W-1:0];
          REG_EXIT_SETTLE:   cfg.exit_settle   = pwdata_i[DELAY_W-1:0];
          REG_LAST_COMMAND:  cfg.last_command  = pwdata_i[CMD_W-1:0];
          default: ;
        endcase
      end
      pending_o = seq_outputs_q.size();
    end
  end

endmodule

>>> tb/tb.sv
// Testbench top for at_command_config_sequencer: clock, reset, APB setup,
// directed and random AT sequences with bursty input and stalling output.
// Depends on acs_pkg, the sequencer RTL and acs_monitor.
module tb;
  import acs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] T0 = 32'hFFFF_FF80;  // directed run wraps through zero

  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  psel             = 1'b0;
  logic                  penable          = 1'b0;
  logic                  pwrite           = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr            = '0;
  logic [31:0]           pwdata           = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid         = 1'b0;
  logic                  in_ready;
  logic [1:0]            op               = OP_NOP;
  logic [31:0]           now_ms           = '0;
  logic [7:0]            rx_byte          = '0;
  logic                  out_valid;
  logic                  out_ready        = 1'b0;
  logic [2:0]            status;
  logic                  start_accepted;
  logic                  enable_level;
  logic                  command_baud;
  logic                  send_command;
  logic [CMD_W-1:0]      command_number;

  int errors;
  int pending;
  int burst_left  = 0;
  int phase_items = 0;
  int ready_mode  = 0;
  int ready_cnt   = 0;

  at_command_config_sequencer uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .op_i             (op),
    .now_ms_i         (now_ms),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .start_accepted_o (start_accepted),
    .enable_level_o   (enable_level),
    .command_baud_o   (command_baud),
    .send_command_o   (send_command),
    .command_number_o (command_number)
  );

  acs_monitor monitor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .op_i             (op),
    .now_ms_i         (now_ms),
    .rx_byte_i        (rx_byte),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .status_i         (status),
    .start_accepted_i (start_accepted),
    .enable_level_i   (enable_level),
    .command_baud_i   (command_baud),
    .send_command_i   (send_command),
    .command_number_i (command_number),
    .errors_o         (errors),
    .pending_o        (pending)
  );

  always #1ns clk_i = ~clk_i;

  // receiver: switches between always-ready, coin-flip, 1-in-4 and rare ready
  always @(posedge clk_i) begin
    if (ready_cnt % 48 == 0) ready_mode = $urandom_range(0, 3);
    ready_cnt++;
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= (ready_cnt % 4 == 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] settle, input logic [15:0] startup,
                            input logic [15:0] reply, input logic [15:0] exit_wait,
                            input logic [3:0] last);
    write_reg(REG_ENABLE_SETTLE, {16'd0, settle});
    write_reg(REG_STARTUP_WAIT, {16'd0, startup});
    write_reg(REG_REPLY_TIMEOUT, {16'd0, reply});
    write_reg(REG_EXIT_SETTLE, {16'd0, exit_wait});
    write_reg(REG_LAST_COMMAND, {28'd0, last});
  endtask

  task automatic send_item(input op_e op_v, input logic [31:0] t, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    op       <= op_v;
    now_ms   <= t;
    rx_byte  <= b;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    burst_left--;
    phase_items++;
  endtask

  task automatic send_rx(input logic [7:0] b);
    send_item(OP_RX, $urandom, b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_rx(s[i]);
  endtask

  // wait until every predicted result has drained, then let the pipeline settle
  task automatic drain();
    int guard;
    guard = 0;
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  // mostly well-formed setup sessions: start, ticks, replies after most ticks
  task automatic run_sessions(input int quota, input int step_max);
    logic [31:0] t;
    int          ticks;
    int          pick;
    phase_items = 0;
    while (phase_items < quota) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(op_e'($urandom_range(0, 3)), $urandom, 8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 3) == 0) t = 32'hFFFF_FFFF - $urandom_range(0, 4 * step_max);
        else t = $urandom;
        send_item(OP_START, t, $urandom);
        ticks = $urandom_range(4, 48);
        while (ticks > 0 && phase_items < quota) begin
          ticks--;
          if ($urandom_range(0, 31) == 0) t = t + $urandom;
          else t = t + $urandom_range(0, step_max);
          send_item(OP_TICK, t, $urandom);
          pick = $urandom_range(0, 31);
          case (pick)
            0:       send_text("ERROR");
            1:       send_text("ERROK");
            2:       send_text("OOK");
            3:       send_rx(8'($urandom_range(0, 255)));
            4:       ;
            5:       send_item(OP_START, t, $urandom);
            6:       send_text("ERRERROR");
            7:       send_text("OKERROR");
            default: send_text("OK");
          endcase
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pass on reset settings: 200/300/1000/200, last command 3
    send_item(OP_NOP, 32'hFFFF_FFFF, 8'hFF);
    send_item(OP_TICK, T0, 8'h00);             // tick while idle
    send_item(OP_START, T0, 8'h00);
    send_item(OP_START, T0 + 32'd5, 8'h00);    // refused while busy
    send_item(OP_TICK, T0 + 32'd199, 8'h00);
    send_rx(8'h00);                            // ignored outside reply wait
    send_item(OP_TICK, T0 + 32'd200, 8'h00);   // deadline past the wrap
    send_rx(8'hFF);
    send_item(OP_TICK, T0 + 32'd500, 8'h00);   // command 0
    send_text("OOK");                          // restart on first char
    send_item(OP_TICK, T0 + 32'd600, 8'h00);   // command 1
    send_text("OKERROR");                      // error beats ok
    send_item(OP_TICK, T0 + 32'd700, 8'h00);
    send_item(OP_TICK, T0 + 32'd800, 8'h00);
    send_item(OP_START, T0 + 32'd800, 8'h00);  // restart after failure
    send_item(OP_TICK, T0 + 32'd1000, 8'h00);
    send_item(OP_TICK, T0 + 32'd1300, 8'h00);
    send_item(OP_TICK, T0 + 32'd2300, 8'h00);  // reply timeout
    drain();

    set_config(16'd5, 16'd3, 16'd20, 16'd4, 4'd2);
    run_sessions(100, 8);
    drain();

    set_config(16'd0, 16'd0, 16'd0, 16'd0, 4'd0);
    run_sessions(80, 3);
    drain();

    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15);
    run_sessions(120, 40000);
    drain();

    // may land mid-sequence with last command below the current index
    set_config(16'($urandom_range(0, 50)), 16'($urandom_range(0, 50)),
               16'($urandom_range(0, 50)), 16'($urandom_range(0, 50)),
               4'($urandom_range(0, 3)));
    run_sessions(100, 60);
    drain();

    repeat (10) @(posedge clk_i);
    if (pending != 0) $error("%0d results never arrived", pending);
    if (errors == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #1ms;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> files.f
rtl/acs_pkg.sv
rtl/acs_cfg_regs.sv
rtl/acs_core.sv
rtl/at_command_config_sequencer.sv
tb/acs_monitor.sv
tb/tb.sv
